// ===== rtl/multichannel_fir_filter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel FIR filter
// Concurrent checks written in one house form, used by the filter module.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_FIR_FILTER_ASSERT_SVH
`define MULTICHANNEL_FIR_FILTER_ASSERT_SVH

// The condition implies the expression in the same cycle.
`define MCFIR_ASSERT_SAME(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// The condition implies the expression in the following cycle.
`define MCFIR_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== rtl/mcfir_pkg.sv =====
// ----------------------------------------------------------------------------
// mcfir_pkg
// Types, codes and sizing constants of the multichannel FIR filter.
// ----------------------------------------------------------------------------
package mcfir_pkg;

    // Default sizes.
    localparam int DEF_MAX_TAPS     = 128;
    localparam int DEF_MAX_CHANNELS = 8;
    localparam int DEF_SAMPLE_WIDTH = 24;

    // Fixed field and register widths.
    localparam int OP_W           = 2;
    localparam int COEF_INDEX_W   = 7;
    localparam int CHANNEL_OUT_W  = 3;
    localparam int NUM_TAPS_W     = 8;
    localparam int NUM_CHANNELS_W = 4;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_ADDR_W     = 3;

    // Reset values of the configuration registers.
    localparam logic [NUM_TAPS_W-1:0]     NUM_TAPS_RESET     = 8'd101;
    localparam logic [NUM_CHANNELS_W-1:0] NUM_CHANNELS_RESET = 4'd1;

    // Register index, taken from paddr[2].
    localparam logic REG_NUM_TAPS     = 1'b0;
    localparam logic REG_NUM_CHANNELS = 1'b1;

    // Accumulator and its saturation bound.
    localparam int ACC_W = 64;
    localparam logic signed [ACC_W-1:0] ACC_LIMIT = 64'sh2000_0000_0000_0000;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE  = 2'd0,
        OP_COEF    = 2'd1,
        OP_DISCONT = 2'd2,
        OP_UNUSED  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_OUT
    } state_t;

endpackage

// ===== rtl/multichannel_fir_filter.sv =====
// ----------------------------------------------------------------------------
// multichannel_fir_filter
// Direct-form FIR over interleaved audio channels, one shared multiply-
// accumulate walking the taps out of a history memory and a coefficient memory.
// ----------------------------------------------------------------------------
//  channel   handshake              tdata (low bit up)                 tuser
//  s_*       s_tvalid / s_tready    sample_in, coef_index, coef_value  op
//  m_*       m_tvalid / m_tready    sample_out                         channel_out
//  apb       psel/penable/pready    num_taps @0x0, num_channels @0x4   -
//
// A sample word is accepted and stored, then its taps are walked through the
// single history read port and multiplier, the read, product and accumulate
// stages drain, and the result is rounded. Other words finish on acceptance.
// The history needs no clearing pass: per-channel fill marks read unwritten
// slots as zero, so the block is ready right after reset.
// A result held on the master side stalls only the rounding step.
// ----------------------------------------------------------------------------
`include "multichannel_fir_filter_assert.svh"

module multichannel_fir_filter
    import mcfir_pkg::*;
#(
    parameter int MAX_TAPS     = DEF_MAX_TAPS,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    localparam int IN_DATA_W   = ((2 * SAMPLE_WIDTH + COEF_INDEX_W + 7) / 8) * 8,
    localparam int OUT_DATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_W-1:0]     s_tdata,   // sample_in, coef_index, coef_value
    input  logic [OP_W-1:0]          s_tuser,   // op

    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_W-1:0]    m_tdata,   // sample_out
    output logic [CHANNEL_OUT_W-1:0] m_tuser,   // channel_out

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_W-1:0]    paddr,
    input  logic [CFG_DATA_W-1:0]    pwdata,
    output logic [CFG_DATA_W-1:0]    prdata,
    output logic                     pready
);

    localparam int W        = SAMPLE_WIDTH;
    localparam int PTR_W    = $clog2(MAX_TAPS);
    localparam int TAP_W    = $clog2(MAX_TAPS + 1);
    localparam int CH_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CHN_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS + 1) : 1;
    localparam int WARM_W   = TAP_W + CHN_W;
    localparam int HADDR_W  = CH_W + PTR_W;
    localparam int HIST_DEPTH = MAX_CHANNELS << PTR_W;

    localparam int CI_LSB = W;
    localparam int CV_LSB = W + COEF_INDEX_W;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'd1 << (W - 3));
    localparam logic signed [ACC_W-1:0] OUT_MAX    = ACC_W'((64'd1 << (W - 1)) - 64'd1);
    localparam logic signed [ACC_W-1:0] OUT_MIN    = ~OUT_MAX;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [NUM_TAPS_W-1:0]     num_taps_reg;
    logic [NUM_CHANNELS_W-1:0] num_channels_reg;
    logic                      cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_taps_reg     <= NUM_TAPS_RESET;
            num_channels_reg <= NUM_CHANNELS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_NUM_TAPS:     num_taps_reg     <= pwdata[NUM_TAPS_W-1:0];
                REG_NUM_CHANNELS: num_channels_reg <= pwdata[NUM_CHANNELS_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_NUM_TAPS:     prdata = CFG_DATA_W'(num_taps_reg);
            REG_NUM_CHANNELS: prdata = CFG_DATA_W'(num_channels_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // Input word fields
    // ------------------------------------------------------------------
    op_t                       in_op;
    logic [W-1:0]              in_sample;
    logic [COEF_INDEX_W-1:0]   in_coef_index;
    logic [W-1:0]              in_coef_value;

    assign in_op         = op_t'(s_tuser);
    assign in_sample     = s_tdata[W-1:0];
    assign in_coef_index = s_tdata[CV_LSB-1:CI_LSB];
    assign in_coef_value = s_tdata[CV_LSB+W-1:CV_LSB];

    // ------------------------------------------------------------------
    // Channel state and per-word setup
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [PTR_W-1:0]  ptr_reg [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] wrap_reg;
    logic [CH_W-1:0]   chan_reg;
    logic [WARM_W-1:0] warm_reg;

    logic [TAP_W-1:0]  taps_eff;
    logic [CHN_W-1:0]  chans_eff;
    logic [CH_W-1:0]   ch_sel;
    logic [CH_W-1:0]   ch_after;
    logic [PTR_W-1:0]  ptr_sel;
    logic [PTR_W-1:0]  ptr_after;
    logic [WARM_W-1:0] warm_target;
    logic              emit_now;

    always_comb
    begin
        if (num_taps_reg == '0)
            taps_eff = TAP_W'(1);
        else if (32'(num_taps_reg) > MAX_TAPS)
            taps_eff = TAP_W'(MAX_TAPS);
        else
            taps_eff = TAP_W'(num_taps_reg);

        if (num_channels_reg == '0)
            chans_eff = CHN_W'(1);
        else if (32'(num_channels_reg) > MAX_CHANNELS)
            chans_eff = CHN_W'(MAX_CHANNELS);
        else
            chans_eff = CHN_W'(num_channels_reg);

        // A counter left beyond a reduced channel count restarts at channel 0.
        ch_sel   = (CHN_W'(chan_reg) < chans_eff) ? chan_reg : '0;
        ch_after = (CHN_W'(ch_sel) + CHN_W'(1) >= chans_eff) ? '0 : ch_sel + CH_W'(1);

        ptr_sel   = ptr_reg[ch_sel];
        ptr_after = (32'(ptr_sel) == MAX_TAPS - 1) ? '0 : ptr_sel + PTR_W'(1);

        warm_target = (WARM_W'(taps_eff) >> 1) * WARM_W'(chans_eff);
        emit_now    = (warm_reg >= warm_target);
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    logic [CH_W-1:0]  cur_ch_reg;
    logic [PTR_W-1:0] cur_ptr_reg;
    logic             cur_wrap_reg;
    logic [TAP_W-1:0] taps_reg;
    logic             emit_reg;
    logic [PTR_W-1:0] tap_cnt_reg;

    logic rd_valid_reg;
    logic rd_mask_reg;
    logic prod_valid_reg;
    logic m_valid_reg;

    logic accept;
    logic last_tap;
    logic issue;
    logic hist_we;
    logic coef_we;
    logic out_load;
    logic out_free;

    assign accept   = s_tvalid && s_tready;
    assign last_tap = (TAP_W'(tap_cnt_reg) + TAP_W'(1) == taps_reg);
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && in_op == OP_SAMPLE)
                    state_next = S_MAC;
            end
            S_MAC:
            begin
                if (last_tap)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!rd_valid_reg && !prod_valid_reg)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!emit_reg || out_free)
                    state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        hist_we  = 1'b0;
        coef_we  = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                hist_we  = s_tvalid && in_op == OP_SAMPLE;
                coef_we  = s_tvalid && in_op == OP_COEF && 32'(in_coef_index) < MAX_TAPS;
            end
            S_MAC:   issue    = 1'b1;
            S_DRAIN: issue    = 1'b0;
            S_OUT:   out_load = emit_reg && out_free;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int c = 0; c < MAX_CHANNELS; c++)
                ptr_reg[c] <= '0;
            wrap_reg     <= '0;
            chan_reg     <= '0;
            warm_reg     <= '0;
            tap_cnt_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_valid_reg   <= issue;
            prod_valid_reg <= rd_valid_reg;

            if (accept && in_op == OP_DISCONT)
            begin
                for (int c = 0; c < MAX_CHANNELS; c++)
                    ptr_reg[c] <= '0;
                wrap_reg <= '0;
                chan_reg <= '0;
                warm_reg <= '0;
            end
            else if (accept && in_op == OP_SAMPLE)
            begin
                ptr_reg[ch_sel] <= ptr_after;
                if (32'(ptr_sel) == MAX_TAPS - 1)
                    wrap_reg[ch_sel] <= 1'b1;
                chan_reg <= ch_after;
                if (!emit_now)
                    warm_reg <= warm_reg + WARM_W'(1);
            end

            if (accept)
                tap_cnt_reg <= '0;
            else if (issue)
                tap_cnt_reg <= tap_cnt_reg + PTR_W'(1);

            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Per-word values captured when the sample is taken.
    always_ff @(posedge clk)
    begin
        if (accept && in_op == OP_SAMPLE)
        begin
            cur_ch_reg   <= ch_sel;
            cur_ptr_reg  <= ptr_sel;
            cur_wrap_reg <= wrap_reg[ch_sel];
            taps_reg     <= taps_eff;
            emit_reg     <= emit_now;
        end
    end

    // ------------------------------------------------------------------
    // Memories. The sample is written in the accept cycle and the tap reads
    // start in the cycle after, so the newest tap already sees it.
    // ------------------------------------------------------------------
    logic signed [W-1:0] hist_mem [HIST_DEPTH];
    logic signed [W-1:0] coef_mem [MAX_TAPS];
    logic signed [W-1:0] hist_q;
    logic signed [W-1:0] coef_q;
    logic [HADDR_W-1:0]  hist_waddr;
    logic [HADDR_W-1:0]  hist_raddr;
    logic [PTR_W:0]      idx_wide;
    logic                tap_mask;

    assign hist_waddr = {ch_sel, ptr_sel};

    always_comb
    begin
        idx_wide = {1'b0, cur_ptr_reg} - {1'b0, tap_cnt_reg};
        if (cur_ptr_reg < tap_cnt_reg)
            idx_wide = idx_wide + (PTR_W + 1)'(MAX_TAPS);
        hist_raddr = {cur_ch_reg, idx_wide[PTR_W-1:0]};
        // Slots not yet written since the last clear read as zero.
        tap_mask   = cur_wrap_reg || (cur_ptr_reg >= tap_cnt_reg);
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_waddr] <= signed'(in_sample);
        hist_q <= hist_mem[hist_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[PTR_W'(in_coef_index)] <= signed'(in_coef_value);
        coef_q <= coef_mem[tap_cnt_reg];
    end

    // ------------------------------------------------------------------
    // Multiply-accumulate and output rounding
    // ------------------------------------------------------------------
    logic signed [2*W-1:0]   prod_reg;
    logic signed [W-1:0]     hist_eff;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] rounded;
    logic signed [ACC_W-1:0] shifted;
    logic [W-1:0]            sat_val;
    logic [W-1:0]            m_data_reg;
    logic [CH_W-1:0]         m_chan_reg;

    assign hist_eff = rd_mask_reg ? hist_q : '0;
    assign acc_sum  = acc_reg + ACC_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        rd_mask_reg <= tap_mask;
        prod_reg    <= hist_eff * coef_q;
        if (accept)
            acc_reg <= '0;
        else if (prod_valid_reg)
        begin
            if (acc_sum > ACC_LIMIT)
                acc_reg <= ACC_LIMIT;
            else if (acc_sum < -ACC_LIMIT)
                acc_reg <= -ACC_LIMIT;
            else
                acc_reg <= acc_sum;
        end
    end

    always_comb
    begin
        rounded = acc_reg + ROUND_BIAS;
        shifted = rounded >>> (W - 2);
        if (shifted > OUT_MAX)
            sat_val = OUT_MAX[W-1:0];
        else if (shifted < OUT_MIN)
            sat_val = OUT_MIN[W-1:0];
        else
            sat_val = shifted[W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= sat_val;
            m_chan_reg <= cur_ch_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'(m_data_reg);
    assign m_tuser  = CHANNEL_OUT_W'(m_chan_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MCFIR_ASSERT_NEXT(a_sample_starts_mac, clk, rst_n,
        accept && in_op == OP_SAMPLE, state_reg == S_MAC,
        "sample word did not start the tap walk")
    `MCFIR_ASSERT_SAME(a_pipe_empty_when_idle, clk, rst_n,
        state_reg == S_IDLE || state_reg == S_OUT, !rd_valid_reg && !prod_valid_reg,
        "tap pipeline still busy outside the tap walk")
    `MCFIR_ASSERT_SAME(a_tap_in_range, clk, rst_n,
        state_reg == S_MAC, TAP_W'(tap_cnt_reg) < taps_reg,
        "tap counter ran past the tap count")
    `MCFIR_ASSERT_SAME(a_acc_bounded, clk, rst_n,
        state_reg == S_OUT, acc_reg <= ACC_LIMIT && acc_reg >= -ACC_LIMIT,
        "accumulator left its saturation range")

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the multichannel FIR filter
// Loads the coefficient memory and then drives sample, coefficient,
// discontinuity and unused words through the input stream. Each accepted
// word updates a bit-exact software filter that queues the expected outputs.
// Every output word is compared with the oldest queued one. Both stream
// sides idle at random, and the block is reconfigured over APB between
// phases once it has gone idle.
// ----------------------------------------------------------------------------
module tb_top;
    import mcfir_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW    = DEF_SAMPLE_WIDTH;
    localparam int NTAPS = DEF_MAX_TAPS;
    localparam int NCHAN = DEF_MAX_CHANNELS;
    localparam int IN_W  = ((2 * SW + COEF_INDEX_W + 7) / 8) * 8;
    localparam int OUT_W = ((SW + 7) / 8) * 8;

    localparam int IDX_LSB = SW;
    localparam int CV_LSB  = SW + COEF_INDEX_W;

    // Long enough to cover the longest sample word.
    localparam int DRAIN_CYCLES = 150;
    localparam int LONG_HOLD    = 400;
    localparam int QUIET_LIMIT  = 2000;

    localparam logic signed [63:0] OUT_MAX = 64'sd8388607;
    localparam logic signed [63:0] OUT_MIN = -64'sd8388608;

    typedef struct packed {
        logic [SW-1:0]            sample;
        logic [CHANNEL_OUT_W-1:0] chan;
    } fir_out_t;

    class fir_tracker;
        logic signed [SW-1:0]           coef_mem [NTAPS];
        logic signed [SW-1:0]           hist_mem [NCHAN][NTAPS];
        logic [COEF_INDEX_W-1:0]        hist_ptr [NCHAN];
        int unsigned                    next_chan;
        int unsigned                    warmup;
        logic [NUM_TAPS_W-1:0]          taps_reg;
        logic [NUM_CHANNELS_W-1:0]      chans_reg;
        fir_out_t                       pending_outputs [$];
        int                             mismatch_count;

        function new();
            foreach (coef_mem[t])
                coef_mem[t] = '0;
            taps_reg = NUM_TAPS_RESET;
            chans_reg = NUM_CHANNELS_RESET;
            mismatch_count = 0;
            clear_history();
        endfunction

        function void clear_history();
            foreach (hist_mem[c, t])
                hist_mem[c][t] = '0;
            foreach (hist_ptr[c])
                hist_ptr[c] = '0;
            next_chan = 0;
            warmup = 0;
        endfunction

        function void set_register(logic reg_idx, logic [CFG_DATA_W-1:0] value);
            if (reg_idx == REG_NUM_CHANNELS)
                chans_reg = value[NUM_CHANNELS_W-1:0];
            else
                taps_reg = value[NUM_TAPS_W-1:0];
        endfunction

        function int pending();
            return pending_outputs.size();
        endfunction

        // Runs one accepted word through the filter and queues its output, if any.
        function void filter_word(op_t op, logic signed [SW-1:0] smp,
                                  logic [COEF_INDEX_W-1:0] idx, logic signed [SW-1:0] cval);
            int unsigned taps;
            int unsigned chans;
            int unsigned ch;
            int unsigned target;
            int unsigned j;
            logic [COEF_INDEX_W-1:0] ptr;
            logic [COEF_INDEX_W-1:0] slot;
            logic signed [63:0] acc;
            logic signed [63:0] y;
            fir_out_t res;
            case (op)
                OP_COEF:
                    coef_mem[idx] = cval;
                OP_DISCONT:
                    clear_history();
                OP_SAMPLE:
                begin
                    taps = (taps_reg == 0) ? 1 : ((taps_reg > NTAPS) ? NTAPS : taps_reg);
                    chans = (chans_reg == 0) ? 1 : ((chans_reg > NCHAN) ? NCHAN : chans_reg);
                    // A counter left beyond a reduced channel count restarts at zero.
                    ch = (next_chan < chans) ? next_chan : 0;
                    ptr = hist_ptr[ch];
                    hist_mem[ch][ptr] = smp;
                    // The sum cannot reach its saturation bound at these sizes.
                    acc = 0;
                    for (j = 0; j < taps; j++)
                    begin
                        slot = ptr - COEF_INDEX_W'(j);
                        acc = acc + hist_mem[ch][slot] * coef_mem[j];
                    end
                    hist_ptr[ch] = ptr + 1'b1;
                    next_chan = (ch + 1 >= chans) ? 0 : ch + 1;
                    target = (taps / 2) * chans;
                    if (warmup < target)
                        warmup++;
                    else
                    begin
                        // Round half up, then clip to the sample range.
                        y = (acc + (64'sd1 <<< (SW - 3))) >>> (SW - 2);
                        if (y > OUT_MAX)
                            y = OUT_MAX;
                        if (y < OUT_MIN)
                            y = OUT_MIN;
                        res.sample = y[SW-1:0];
                        res.chan = CHANNEL_OUT_W'(ch);
                        pending_outputs.push_back(res);
                    end
                end
                default:
                    ;
            endcase
        endfunction

        task flag_mismatch(string msg);
            $display("[%0t] %s", $time, msg);
            mismatch_count++;
        endtask

        task check_output(logic [SW-1:0] got_sample, logic [CHANNEL_OUT_W-1:0] got_chan);
            fir_out_t want;
            if (pending_outputs.size() == 0)
            begin
                flag_mismatch($sformatf("output word %h on channel %0d with none expected",
                                        got_sample, got_chan));
                return;
            end
            want = pending_outputs.pop_front();
            if (got_sample !== want.sample)
                flag_mismatch($sformatf("sample_out %h, expected %h", got_sample, want.sample));
            if (got_chan !== want.chan)
                flag_mismatch($sformatf("channel_out %0d, expected %0d", got_chan, want.chan));
        endtask
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_W-1:0]          s_tdata;    // sample_in, coef_index, coef_value
    logic [OP_W-1:0]          s_tuser;    // op
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_W-1:0]         m_tdata;    // sample_out
    logic [CHANNEL_OUT_W-1:0] m_tuser;    // channel_out
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_W-1:0]    paddr;
    logic [CFG_DATA_W-1:0]    pwdata;
    logic [CFG_DATA_W-1:0]    prdata;
    logic                     pready;

    fir_tracker tracker = new();

    int src_gap_max = 0;
    int sink_gap_max = 0;
    int sink_holds_asked = 0;
    int sink_holds_done = 0;
    int quiet_cycles = 0;

    multichannel_fir_filter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Both handshakes are sampled with the values they held before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                tracker.filter_word(op_t'(s_tuser), s_tdata[SW-1:0],
                                    s_tdata[IDX_LSB +: COEF_INDEX_W], s_tdata[CV_LSB +: SW]);
            if (m_tvalid && m_tready)
                tracker.check_output(m_tdata[SW-1:0], m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Output side: a random wait before each word, plus the occasional long hold.
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(sink_gap_max, 0);
            if (sink_holds_done != sink_holds_asked)
            begin
                gap = LONG_HOLD;
                sink_holds_done++;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready))
                @(posedge clk);
        end
    end

    function logic [SW-1:0] rand_sample();
        case ($urandom_range(9, 0))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            default: return SW'($urandom);
        endcase
    endfunction

    // Coefficients of mixed magnitude, so that not every output clips.
    function logic signed [SW-1:0] rand_coef();
        logic signed [SW-1:0] v;
        v = SW'($urandom);
        return v >>> $urandom_range(10, 0);
    endfunction

    task send_word(op_t op, logic [SW-1:0] smp, logic [COEF_INDEX_W-1:0] idx,
                   logic [SW-1:0] cval);
        int gap;
        gap = $urandom_range(src_gap_max, 0);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_W'({cval, idx, smp});
        s_tuser <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stops the input and waits until the block has nothing left in flight.
    task settle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes a register with random upper bits, then reads it back.
    task reg_write(logic reg_idx, int unsigned value);
        logic [CFG_DATA_W-1:0] wdata;
        logic [CFG_DATA_W-1:0] stored;
        wdata = $urandom;
        stored = '0;
        if (reg_idx == REG_NUM_CHANNELS)
        begin
            wdata[NUM_CHANNELS_W-1:0] = NUM_CHANNELS_W'(value);
            stored[NUM_CHANNELS_W-1:0] = NUM_CHANNELS_W'(value);
        end
        else
        begin
            wdata[NUM_TAPS_W-1:0] = NUM_TAPS_W'(value);
            stored[NUM_TAPS_W-1:0] = NUM_TAPS_W'(value);
        end
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        tracker.set_register(reg_idx, stored);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== stored)
            tracker.flag_mismatch($sformatf("register %0d reads %h, expected %h",
                                            reg_idx, prdata, stored));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task run_phase(int taps, int chans, bit clear_first, int words, int disc_pct,
                   bit long_hold, int src_max, int sink_max);
        int n;
        int r;
        op_t op;
        settle();
        src_gap_max = src_max;
        sink_gap_max = sink_max;
        reg_write(REG_NUM_TAPS, taps);
        reg_write(REG_NUM_CHANNELS, chans);
        if (clear_first)
            send_word(OP_DISCONT, rand_sample(), COEF_INDEX_W'($urandom), rand_coef());
        n = 0;
        while (n < words)
        begin
            if (long_hold && n == words / 3)
                sink_holds_asked++;
            r = $urandom_range(99, 0);
            if (r < disc_pct)
                op = OP_DISCONT;
            else if (r < disc_pct + 3)
                op = OP_UNUSED;
            else if (r < disc_pct + 11)
                op = OP_COEF;
            else
                op = OP_SAMPLE;
            send_word(op, rand_sample(), COEF_INDEX_W'($urandom_range(NTAPS - 1, 0)),
                      rand_coef());
            if (op != OP_UNUSED)
                n++;
        end
    endtask

    initial
    begin
        int i;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= OP_SAMPLE;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every coefficient is written before any sample can read it.
        src_gap_max = 2;
        sink_gap_max = 2;
        for (i = 0; i < NTAPS; i++)
            send_word(OP_COEF, SW'($urandom), COEF_INDEX_W'(i), rand_coef());

        // Three taps on two channels: clipping both ways, then rounding of ties.
        settle();
        reg_write(REG_NUM_TAPS, 3);
        reg_write(REG_NUM_CHANNELS, 2);
        send_word(OP_COEF, 24'h000000, 7'd0, 24'h7FFFFF);
        send_word(OP_COEF, 24'h000000, 7'd1, 24'h400000);
        send_word(OP_COEF, 24'h000000, 7'd2, 24'h800000);
        send_word(OP_COEF, 24'h000000, 7'd127, 24'h800000);
        send_word(OP_UNUSED, 24'hFFFFFF, 7'd127, 24'hFFFFFF);
        send_word(OP_SAMPLE, 24'h000000, 7'd0, 24'h000000);
        send_word(OP_SAMPLE, 24'h000000, 7'd0, 24'h000000);
        send_word(OP_SAMPLE, 24'h7FFFFF, 7'd0, 24'h000000);
        send_word(OP_SAMPLE, 24'h800000, 7'd0, 24'h000000);
        send_word(OP_SAMPLE, 24'hFFFFFF, 7'd0, 24'h000000);
        send_word(OP_SAMPLE, 24'h000001, 7'd0, 24'h000000);
        send_word(OP_SAMPLE, 24'h7FFFFF, 7'd0, 24'h000000);
        send_word(OP_SAMPLE, 24'h800000, 7'd0, 24'h000000);
        send_word(OP_DISCONT, 24'h000000, 7'd0, 24'h000000);
        send_word(OP_COEF, 24'h000000, 7'd0, 24'h200000);
        send_word(OP_COEF, 24'h000000, 7'd1, 24'h000000);
        send_word(OP_COEF, 24'h000000, 7'd2, 24'h000000);
        send_word(OP_SAMPLE, 24'h000000, 7'd0, 24'h000000);
        send_word(OP_SAMPLE, 24'h000000, 7'd0, 24'h000000);
        send_word(OP_SAMPLE, 24'h000001, 7'd0, 24'h000000);
        send_word(OP_SAMPLE, 24'hFFFFFF, 7'd0, 24'h000000);
        send_word(OP_SAMPLE, 24'h000003, 7'd0, 24'h000000);
        send_word(OP_SAMPLE, 24'hFFFFFD, 7'd0, 24'h000000);

        run_phase(5, 2, 1'b1, 40, 3, 1'b1, 5, 5);
        run_phase(0, 0, 1'b1, 30, 3, 1'b0, 0, 0);
        run_phase(1, 8, 1'b1, 35, 3, 1'b0, 2, 5);
        // No clear after shrinking the channel count.
        run_phase(4, 3, 1'b0, 35, 3, 1'b0, 5, 0);
        run_phase(128, 1, 1'b1, 100, 0, 1'b0, 3, 3);
        // Same warm-up length as before, so outputs flow at once.
        run_phase(255, 1, 1'b0, 60, 0, 1'b1, 0, 5);
        run_phase(9, 15, 1'b1, 40, 3, 1'b0, 5, 2);
        run_phase(7, 4, 1'b1, 40, 3, 1'b0, 1, 1);

        settle();
        if (tracker.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mcfir_pkg.sv
rtl/multichannel_fir_filter.sv
tb/tb_top.sv
